/* rtl/linear_probe_hash_table_core_macros.svh */
// Assertion macros used by the hash table checker.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LPHT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPHT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lpht_pkg.sv */
// Shared types and constants for the linear probing hash table.
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int MAX_KEY_BYTES   = 8;
    localparam logic [8:0]  TABLE_SIZE_RESET = 9'd256;
    localparam logic [63:0] DJB2_SEED        = 64'd5381;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_ABSENT   = 3'd4
    } status_t;

    typedef struct packed {
        logic        func;
        logic [63:0] key;
        logic [3:0]  key_len;
        logic [31:0] handle;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_handle;
        logic [7:0]  slot;
        logic [8:0]  entry_total;
    } rsp_t;

endpackage

/* rtl/linear_probe_hash_table_core.sv */
// Top level: djb2-hashed key-to-handle table with linear probing over slot memories.
// Steps: hash the key byte by byte over n bytes, n the key length after the 8-byte clamp
//   and the first zero byte; take the remainder by the size; then fetch and check per probe.
// Throughput: one request at a time; start is taken again in the cycle done is high.
// Reset: valid bits cleared one slot at a time with busy high; table_size is 256.
// Results cannot be stalled: done is a one-cycle strobe.
`timescale 1ns / 1ps

module linear_probe_hash_table_core #(
    parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lpht_pkg::req_t req,
    output logic          done,
    output lpht_pkg::rsp_t result,
    input  logic          cfg_we,
    input  logic [8:0]    cfg_wdata
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = IDX_W + 10;

    typedef struct packed {
        logic [3:0]  key_len;
        logic [63:0] key;
        logic [31:0] handle;
    } entry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_DIV,
        S_FETCH,
        S_CHECK
    } state_t;

    state_t            state_reg;
    logic [8:0]        table_size_reg;
    logic              func_reg;
    logic [63:0]       key_reg;
    logic [3:0]        len_reg;
    logic [31:0]       handle_reg;
    logic [8:0]        sz_reg;
    logic [63:0]       hash_reg;
    logic [63:0]       key_sh_reg;
    logic [3:0]        hash_left_reg;
    logic [63:0]       div_reg;
    logic [8:0]        rem_reg;
    logic [3:0]        div_cnt_reg;
    logic [IDX_W-1:0]  bin_reg;
    logic [IDX_W-1:0]  start_slot_reg;
    logic [8:0]        probes_left_reg;
    logic [IDX_W-1:0]  clr_cnt_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              done_reg;
    rsp_t              result_reg;

    // slot memories: valid bits are cleared after reset, entries are not
    logic              valid_mem [TABLE_DEPTH];
    entry_t            data_mem  [TABLE_DEPTH];
    logic              vld_rd_reg;
    entry_t            ent_rd_reg;

    logic [8:0]        sz_next;
    logic [3:0]        eff_len;
    logic [63:0]       key_masked;
    logic [63:0]       hash_next;
    logic [63:0]       div_next;
    logic [8:0]        rem_next;
    logic [IDX_W+8:0]  rem_ext;
    logic [IDX_W+7:0]  bin_ext;
    logic [IDX_W+7:0]  start_ext;
    logic [CNT_W+8:0]  count_ext;
    logic [CNT_W+8:0]  count_inc_ext;
    logic [CNT_W-1:0]  count_inc;
    logic [CMP_W-1:0]  bin_inc;
    logic [IDX_W-1:0]  bin_wrap;
    logic              key_match;
    logic              ins_we;
    logic              vm_we;
    logic [IDX_W-1:0]  vm_addr;
    logic              vm_wdata;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // size in use: 0 acts as 1, anything above the depth acts as the depth
    always_comb
    begin
        if (table_size_reg == 9'd0)
            sz_next = 9'd1;
        else if ({23'd0, table_size_reg} > 32'(TABLE_DEPTH))
            sz_next = 9'(TABLE_DEPTH);
        else
            sz_next = table_size_reg;
    end

    // effective key: clamp the length, stop at the first zero byte, mask the rest
    always_comb
    begin
        logic [3:0] lim;
        logic       alive;
        lim   = (req.key_len > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES) : req.key_len;
        alive = 1'b1;
        eff_len = 4'd0;
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            if (alive && (4'(i) < lim) && (req.key[8*i +: 8] != 8'h00))
                eff_len = 4'(i + 1);
            else
                alive = 1'b0;
        end
        for (int i = 0; i < 8; i++)
            key_masked[8*i +: 8] = (4'(i) < eff_len) ? req.key[8*i +: 8] : 8'h00;
    end

    // h * 33 + byte
    assign hash_next = (hash_reg << 5) + hash_reg + {56'd0, key_sh_reg[7:0]};

    // four restoring remainder steps per cycle, dividend MSB first
    always_comb
    begin
        logic [9:0]  t;
        logic [8:0]  r;
        logic [63:0] d;
        r = rem_reg;
        d = div_reg;
        for (int j = 0; j < 4; j++)
        begin
            t = {r, d[63]};
            d = d << 1;
            if (t >= {1'b0, sz_reg})
                t = t - {1'b0, sz_reg};
            r = t[8:0];
        end
        rem_next = r;
        div_next = d;
    end

    assign rem_ext       = {{IDX_W{1'b0}}, rem_next};
    assign bin_ext       = {8'd0, bin_reg};
    assign start_ext     = {8'd0, start_slot_reg};
    assign count_inc     = count_reg + 1'b1;
    assign count_ext     = {9'd0, count_reg};
    assign count_inc_ext = {9'd0, count_inc};
    assign bin_inc       = CMP_W'(bin_reg) + 1'b1;
    assign bin_wrap      = (bin_inc == CMP_W'(sz_reg)) ? '0 : bin_inc[IDX_W-1:0];

    assign key_match = (ent_rd_reg.key_len == len_reg) && (ent_rd_reg.key == key_reg);
    assign ins_we    = (state_reg == S_CHECK) && !vld_rd_reg && (func_reg == FUNC_INSERT);

    always_comb
    begin
        vm_we    = 1'b0;
        vm_addr  = bin_reg;
        vm_wdata = 1'b1;
        if (state_reg == S_CLEAR)
        begin
            vm_we    = 1'b1;
            vm_addr  = clr_cnt_reg;
            vm_wdata = 1'b0;
        end
        else if (ins_we)
        begin
            vm_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vm_we)
            valid_mem[vm_addr] <= vm_wdata;
        if (ins_we)
            data_mem[bin_reg] <= '{key_len: len_reg, key: key_reg, handle: handle_reg};
        if (state_reg == S_FETCH)
        begin
            vld_rd_reg <= valid_mem[bin_reg];
            ent_rd_reg <= data_mem[bin_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            table_size_reg  <= TABLE_SIZE_RESET;
            func_reg        <= FUNC_INSERT;
            key_reg         <= '0;
            len_reg         <= '0;
            handle_reg      <= '0;
            sz_reg          <= '0;
            hash_reg        <= '0;
            key_sh_reg      <= '0;
            hash_left_reg   <= '0;
            div_reg         <= '0;
            rem_reg         <= '0;
            div_cnt_reg     <= '0;
            bin_reg         <= '0;
            start_slot_reg  <= '0;
            probes_left_reg <= '0;
            clr_cnt_reg     <= '0;
            count_reg       <= '0;
            done_reg        <= 1'b0;
            result_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
                table_size_reg <= cfg_wdata;

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == IDX_W'(TABLE_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        func_reg      <= req.func;
                        key_reg       <= key_masked;
                        key_sh_reg    <= key_masked;
                        len_reg       <= eff_len;
                        hash_left_reg <= eff_len;
                        handle_reg    <= req.handle;
                        sz_reg        <= sz_next;
                        hash_reg      <= DJB2_SEED;
                        state_reg     <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (hash_left_reg == 4'd0)
                    begin
                        div_reg     <= hash_reg;
                        rem_reg     <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end
                    else
                    begin
                        hash_reg      <= hash_next;
                        key_sh_reg    <= key_sh_reg >> 8;
                        hash_left_reg <= hash_left_reg - 1'b1;
                    end
                end
                S_DIV:
                begin
                    rem_reg     <= rem_next;
                    div_reg     <= div_next;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 4'd15)
                    begin
                        bin_reg         <= rem_ext[IDX_W-1:0];
                        start_slot_reg  <= rem_ext[IDX_W-1:0];
                        probes_left_reg <= sz_reg;
                        state_reg       <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (!vld_rd_reg)
                    begin
                        done_reg                <= 1'b1;
                        result_reg.found_handle <= '0;
                        result_reg.slot         <= bin_ext[7:0];
                        state_reg               <= S_IDLE;
                        if (func_reg == FUNC_INSERT)
                        begin
                            count_reg              <= count_inc;
                            result_reg.status      <= ST_INSERTED;
                            result_reg.entry_total <= count_inc_ext[8:0];
                        end
                        else
                        begin
                            result_reg.status      <= ST_ABSENT;
                            result_reg.entry_total <= count_ext[8:0];
                        end
                    end
                    else if (key_match)
                    begin
                        done_reg               <= 1'b1;
                        result_reg.slot        <= bin_ext[7:0];
                        result_reg.entry_total <= count_ext[8:0];
                        state_reg              <= S_IDLE;
                        if (func_reg == FUNC_INSERT)
                        begin
                            result_reg.status       <= ST_PRESENT;
                            result_reg.found_handle <= '0;
                        end
                        else
                        begin
                            result_reg.status       <= ST_FOUND;
                            result_reg.found_handle <= ent_rd_reg.handle;
                        end
                    end
                    else if (probes_left_reg == 9'd1)
                    begin
                        // every slot in use probed, no hit and no hole
                        done_reg                <= 1'b1;
                        result_reg.status       <= (func_reg == FUNC_INSERT) ? ST_FULL
                                                                             : ST_ABSENT;
                        result_reg.found_handle <= '0;
                        result_reg.slot         <= start_ext[7:0];
                        result_reg.entry_total  <= count_ext[8:0];
                        state_reg               <= S_IDLE;
                    end
                    else
                    begin
                        bin_reg         <= bin_wrap;
                        probes_left_reg <= probes_left_reg - 1'b1;
                        state_reg       <= S_FETCH;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/lpht_checker.sv */
// Port-level checker for the hash table core and its bind statement.
`timescale 1ns / 1ps
`include "linear_probe_hash_table_core_macros.svh"

module lpht_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input lpht_pkg::rsp_t result
);
    import lpht_pkg::*;

    // a taken request keeps the core busy in the next cycle
    `LPHT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")

    // a result beat lasts one cycle and never follows another directly
    `LPHT_ASSERT_NXT(a_done_single, done, !done, "result strobe held for two cycles")

    // the result beat ends a busy period
    `LPHT_ASSERT_IMP(a_done_after_busy, done, !busy && $past(busy),
                     "result strobe outside the end of a request")

    // only a found lookup carries a handle
    `LPHT_ASSERT_IMP(a_handle_zero, done && (result.status != ST_FOUND),
                     result.found_handle == 32'd0, "handle set on a result that is not found")

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
